>>> rtl/gqdp_pkg.sv
package gqdp_pkg;

   // code width settings of the format register
   localparam logic [1:0] FMT_Q4 = 2'd0;
   localparam logic [1:0] FMT_Q5 = 2'd1;
   localparam logic [1:0] FMT_Q6 = 2'd2;
   localparam logic [1:0] FMT_Q8 = 2'd3;
   localparam logic [1:0] FMT_RESET = FMT_Q8;

   localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

   typedef logic signed [11:0] fexp_type;

   // unpacked operand: value = (-1)^sign * man * 2^expo
   typedef struct packed {
      logic       sign;
      logic [23:0] man;
      fexp_type   expo;
      logic       nan;
      logic       inf;
      logic       zero;
   } fp_unp_type;

   function automatic fp_unp_type unpack_single(input logic [31:0] u);
      fp_unp_type r;
      r.sign = u[31];
      r.man  = {(u[30:23] != 8'd0), u[22:0]};
      r.expo = ((u[30:23] == 8'd0) ? 12'sd1 : $signed({4'b0, u[30:23]})) - 12'sd150;
      r.nan  = (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
      r.inf  = (u[30:23] == 8'hFF) && (u[22:0] == 23'd0);
      r.zero = (u[30:0] == 31'd0);
      return r;
   endfunction

   function automatic fp_unp_type unpack_half(input logic [15:0] h);
      fp_unp_type r;
      r.sign = h[15];
      r.man  = {13'd0, (h[14:10] != 5'd0), h[9:0]};
      r.expo = ((h[14:10] == 5'd0) ? 12'sd1 : $signed({7'b0, h[14:10]})) - 12'sd25;
      r.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
      r.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
      r.zero = (h[14:0] == 15'd0);
      return r;
   endfunction

   function automatic logic [31:0] half_nan_bits(input logic [15:0] h);
      return {h[15], 8'hFF, h[9:0], 13'd0};
   endfunction

   // right shift, shifted-out bits folded into the lsb
   function automatic logic [63:0] shr_sticky(input logic [63:0] v, input logic [11:0] d);
      logic [63:0] r;
      logic [63:0] mask;
      if (d >= 12'd64) begin
         r = {63'd0, |v};
      end else begin
         r    = v >> d[5:0];
         mask = ~({64{1'b1}} << d[5:0]);
         r[0] = r[0] | (|(v & mask));
      end
      return r;
   endfunction

   function automatic logic [15:0] to_bf16(input logic [31:0] u);
      logic [32:0] t;
      t = {1'b0, u} + 33'h0_7FFF + {32'd0, u[16]};
      if ((u[30:23] == 8'hFF) && (u[22:0] != 23'd0)) begin
         return u[31:16] | 16'h0040;
      end
      return t[31:16];
   endfunction

   function automatic logic signed [7:0] elem_decode(input logic [1:0] fmt,
                                                     input logic [7:0] cb,
                                                     input logic [7:0] hb,
                                                     input logic [5:0] lane);
      logic [3:0] nib;
      logic [4:0] f5;
      logic [7:0] hs;
      logic [5:0] f6;
      logic signed [7:0] r;
      nib = lane[0] ? cb[7:4] : cb[3:0];
      f5  = {hb[lane[2:0]], nib};
      hs  = hb >> {lane[1:0], 1'b0};
      f6  = {hs[1:0], nib};
      case (fmt)
         FMT_Q4:  r = {{4{nib[3]}}, nib};
         FMT_Q5:  r = {{3{f5[4]}}, f5};
         FMT_Q6:  r = {{2{f6[5]}}, f6};
         default: r = cb;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/gqdp_if.sv
interface gqdp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  code_byte;
   logic [7:0]  high_byte;
   logic [5:0]  lane;
   logic [31:0] activation;
   logic [15:0] scale_half;
   logic        group_end;
   logic        dot_end;
   modport source (output valid, code_byte, high_byte, lane, activation, scale_half,
                   group_end, dot_end, input ready);
   modport sink (input valid, code_byte, high_byte, lane, activation, scale_half,
                 group_end, dot_end, output ready);
endinterface

interface gqdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result_bf16;
   modport source (output valid, result_bf16, input ready);
   modport sink (input valid, result_bf16, output ready);
endinterface

interface gqdp_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] code_format;
   modport source (output valid, code_format, input ready);
   modport sink (input valid, code_format, output ready);
endinterface

>>> rtl/group_quant_dot_product.sv
// A group end or a dot end adds a second multiply-add (group sum into dot sum), and a dot end
// then issues the result beat, held back while an earlier result beat still waits; NaN,
// infinity and zero shortcuts skip the multiply, normalise, align and round steps. One element
// at a time: a new beat is taken only once the shared multiply-add datapath (multiplier, 64-bit
// normaliser, aligner, rounder) is idle again.
// Synchronous active-high reset: both sums cleared to +0, code_format to eight-bit codes.
module group_quant_dot_product
   import gqdp_pkg::*;
(
   input logic      clock,
   input logic      reset,
   gqdp_req_if.sink   req,
   gqdp_rsp_if.source rsp,
   gqdp_csr_if.sink   csr
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_MUL    = 4'd2;
   localparam logic [3:0] ST_NRMP   = 4'd3;
   localparam logic [3:0] ST_NRMC   = 4'd4;
   localparam logic [3:0] ST_ALIGN  = 4'd5;
   localparam logic [3:0] ST_NRMS   = 4'd6;
   localparam logic [3:0] ST_DENORM = 4'd7;
   localparam logic [3:0] ST_ROUND  = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   localparam logic [2:0] LAST_STEP = 3'd5;

   // control
   logic [3:0]  state_ff, state_in;
   logic [1:0]  fmt_ff, fmt_in;
   logic        phase_ff, phase_in;      // 0: element into group sum, 1: group into dot sum
   logic [31:0] group_sum_ff, group_sum_in;
   logic [31:0] dot_sum_ff, dot_sum_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  step_ff, step_in;

   // payload
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        csign_ff, csign_in;
   logic [7:0]  cmag_ff, cmag_in;
   logic [31:0] act_ff, act_in;
   logic [15:0] scale_ff, scale_in;
   logic        gend_ff, gend_in;
   logic        dend_ff, dend_in;
   logic        sp_ff, sp_in;
   logic [23:0] ma_ff, ma_in;
   logic [23:0] mb_ff, mb_in;
   fexp_type    ep_ff, ep_in;
   logic        sc_ff, sc_in;
   logic [23:0] mc_ff, mc_in;
   fexp_type    ec_ff, ec_in;
   logic        czero_ff, czero_in;
   logic [63:0] pw_ff, pw_in;
   fexp_type    pe_ff, pe_in;
   logic [63:0] nrm_ff, nrm_in;
   fexp_type    nrm_e_ff, nrm_e_in;
   logic        rsgn_ff, rsgn_in;
   logic [7:0]  bexp_ff, bexp_in;
   logic [31:0] res_ff, res_in;

   // datapath wires
   logic signed [7:0] code;
   fp_unp_type  ua, ub, uc;
   logic [31:0] b_bits, c_bits;
   logic        p_sign;
   logic [47:0] prod;
   logic        top_zero;
   logic [5:0]  nsh;
   logic [63:0] nrm_step;
   fexp_type    nrm_e_step;
   logic [63:0] xp, xc, ax, ay, shift_src, asum;
   logic [11:0] shift_d;
   logic        p_big, sx, sy, asgn;
   fexp_type    ae, bq;
   logic        inc;

   assign req.ready       = (state_ff == ST_IDLE);
   assign csr.ready       = 1'b1;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_bf16 = rsp_data_ff;

   // decode the element code as the beat arrives
   assign code = elem_decode(fmt_ff, req.code_byte, req.high_byte, req.lane);

   // operand selection: element pass uses code * activation + group sum,
   // group pass uses group sum * scale + dot sum
   always_comb begin
      if (phase_ff) begin
         ua     = unpack_single(group_sum_ff);
         ub     = unpack_half(scale_ff);
         b_bits = half_nan_bits(scale_ff);
         c_bits = dot_sum_ff;
      end else begin
         ua.sign = csign_ff;
         ua.man  = {16'd0, cmag_ff};
         ua.expo = 12'sd0;
         ua.nan  = 1'b0;
         ua.inf  = 1'b0;
         ua.zero = (cmag_ff == 8'd0);
         ub      = unpack_single(act_ff);
         b_bits  = act_ff;
         c_bits  = group_sum_ff;
      end
      uc     = unpack_single(c_bits);
      p_sign = ua.sign ^ ub.sign;
   end

   assign prod = ma_ff * mb_ff;

   // normaliser: one binary step per cycle, shifts of 32, 16, 8, 4, 2 and 1
   always_comb begin
      case (step_ff)
         3'd0: begin
            top_zero = (nrm_ff[63:32] == 32'd0);
            nsh      = 6'd32;
         end
         3'd1: begin
            top_zero = (nrm_ff[63:48] == 16'd0);
            nsh      = 6'd16;
         end
         3'd2: begin
            top_zero = (nrm_ff[63:56] == 8'd0);
            nsh      = 6'd8;
         end
         3'd3: begin
            top_zero = (nrm_ff[63:60] == 4'd0);
            nsh      = 6'd4;
         end
         3'd4: begin
            top_zero = (nrm_ff[63:62] == 2'd0);
            nsh      = 6'd2;
         end
         default: begin
            top_zero = ~nrm_ff[63];
            nsh      = 6'd1;
         end
      endcase
      nrm_step   = top_zero ? (nrm_ff << nsh) : nrm_ff;
      nrm_e_step = top_zero ? (nrm_e_ff - $signed({6'd0, nsh})) : nrm_e_ff;
   end

   // aligner and adder: larger exponent stays, the other shifts right with sticky
   always_comb begin
      xp        = {1'b0, pw_ff[63:16], 15'd0};
      xc        = {1'b0, nrm_ff[63:16], 15'd0};
      p_big     = czero_ff || (pe_ff >= nrm_e_ff);
      shift_src = p_big ? xc : xp;
      shift_d   = p_big ? $unsigned(pe_ff - nrm_e_ff) : $unsigned(nrm_e_ff - pe_ff);
      ax        = p_big ? xp : xc;
      ay        = czero_ff ? 64'd0 : shr_sticky(shift_src, shift_d);
      ae        = (p_big ? pe_ff : nrm_e_ff) + 12'sd1;
      sx        = p_big ? sp_ff : sc_ff;
      sy        = p_big ? sc_ff : sp_ff;
      if (sx == sy) begin
         asum = ax + ay;
         asgn = sx;
      end else if (ax >= ay) begin
         asum = ax - ay;
         asgn = sx;
      end else begin
         asum = ay - ax;
         asgn = sy;
      end
   end

   // biased exponent of the normalised sum and round-to-nearest-even increment
   assign bq  = nrm_e_ff + 12'sd190;
   assign inc = nrm_ff[39] & ((|nrm_ff[38:0]) | nrm_ff[40]);

   always_comb begin
      state_in     = state_ff;
      fmt_in       = fmt_ff;
      phase_in     = phase_ff;
      group_sum_in = group_sum_ff;
      dot_sum_in   = dot_sum_ff;
      rsp_valid_in = rsp_valid_ff;
      step_in      = step_ff;
      rsp_data_in  = rsp_data_ff;
      csign_in     = csign_ff;
      cmag_in      = cmag_ff;
      act_in       = act_ff;
      scale_in     = scale_ff;
      gend_in      = gend_ff;
      dend_in      = dend_ff;
      sp_in        = sp_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      ep_in        = ep_ff;
      sc_in        = sc_ff;
      mc_in        = mc_ff;
      ec_in        = ec_ff;
      czero_in     = czero_ff;
      pw_in        = pw_ff;
      pe_in        = pe_ff;
      nrm_in       = nrm_ff;
      nrm_e_in     = nrm_e_ff;
      rsgn_in      = rsgn_ff;
      bexp_in      = bexp_ff;
      res_in       = res_ff;

      if (csr.valid) begin
         fmt_in = csr.code_format;
      end

      // drop the result beat once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               csign_in = code[7];
               cmag_in  = code[7] ? 8'(-code) : 8'(code);
               act_in   = req.activation;
               scale_in = req.scale_half;
               gend_in  = req.group_end;
               dend_in  = req.dot_end;
               phase_in = 1'b0;
               state_in = ST_LOAD;
            end
         end

         ST_LOAD: begin
            // settle NaN, infinity and zero operands here; the rest go through the datapath
            sp_in    = p_sign;
            ma_in    = ua.man;
            mb_in    = ub.man;
            ep_in    = ua.expo + ub.expo;
            sc_in    = uc.sign;
            mc_in    = uc.man;
            ec_in    = uc.expo;
            czero_in = uc.zero;
            state_in = ST_DONE;
            if (ua.nan) begin
               res_in = group_sum_ff | QUIET_BIT;
            end else if (ub.nan) begin
               res_in = b_bits | QUIET_BIT;
            end else if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
               res_in = DEFAULT_NAN;
            end else if (uc.nan) begin
               res_in = c_bits | QUIET_BIT;
            end else if ((ua.inf || ub.inf) && uc.inf && (p_sign != uc.sign)) begin
               res_in = DEFAULT_NAN;
            end else if (ua.inf || ub.inf) begin
               res_in = {p_sign, 31'h7F80_0000};
            end else if (uc.inf) begin
               res_in = c_bits;
            end else if (ua.zero || ub.zero) begin
               res_in = uc.zero ? {p_sign & uc.sign, 31'd0} : c_bits;
            end else begin
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            nrm_in   = {prod, 16'd0};
            nrm_e_in = ep_ff - 12'sd16;
            step_in  = 3'd0;
            state_in = ST_NRMP;
         end

         ST_NRMP: begin
            nrm_in   = nrm_step;
            nrm_e_in = nrm_e_step;
            step_in  = step_ff + 3'd1;
            if (step_ff == LAST_STEP) begin
               // park the product, load the addend into the normaliser
               pw_in    = nrm_step;
               pe_in    = nrm_e_step;
               nrm_in   = {mc_ff, 40'd0};
               nrm_e_in = ec_ff - 12'sd40;
               step_in  = 3'd0;
               state_in = ST_NRMC;
            end
         end

         ST_NRMC: begin
            nrm_in   = nrm_step;
            nrm_e_in = nrm_e_step;
            step_in  = step_ff + 3'd1;
            if (step_ff == LAST_STEP) begin
               step_in  = 3'd0;
               state_in = ST_ALIGN;
            end
         end

         ST_ALIGN: begin
            if (asum == 64'd0) begin
               // exact cancellation gives +0
               res_in   = 32'd0;
               state_in = ST_DONE;
            end else begin
               nrm_in   = asum;
               nrm_e_in = ae;
               rsgn_in  = asgn;
               step_in  = 3'd0;
               state_in = ST_NRMS;
            end
         end

         ST_NRMS: begin
            nrm_in   = nrm_step;
            nrm_e_in = nrm_e_step;
            step_in  = step_ff + 3'd1;
            if (step_ff == LAST_STEP) begin
               step_in  = 3'd0;
               state_in = ST_DENORM;
            end
         end

         ST_DENORM: begin
            state_in = ST_ROUND;
            if (bq >= 12'sd255) begin
               res_in   = {rsgn_ff, 8'hFF, 23'd0};
               state_in = ST_DONE;
            end else if (bq <= 12'sd0) begin
               // subnormal: shift down to the fixed exponent
               nrm_in  = shr_sticky(nrm_ff, $unsigned(12'sd1 - bq));
               bexp_in = 8'd0;
            end else begin
               bexp_in = bq[7:0];
            end
         end

         ST_ROUND: begin
            // a carry out of the fraction advances the exponent, up to infinity
            res_in   = {rsgn_ff, {bexp_ff, nrm_ff[62:40]} + {30'd0, inc}};
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!phase_ff) begin
               group_sum_in = res_ff;
               if (gend_ff || dend_ff) begin
                  phase_in = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               dot_sum_in   = res_ff;
               group_sum_in = 32'd0;
               phase_in     = 1'b0;
               state_in     = dend_ff ? ST_OUT : ST_IDLE;
            end
         end

         ST_OUT: begin
            // hold until the result slot is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = to_bf16(dot_sum_ff);
               dot_sum_in   = 32'd0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fmt_ff       <= FMT_RESET;
         phase_ff     <= 1'b0;
         group_sum_ff <= 32'd0;
         dot_sum_ff   <= 32'd0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
      end else begin
         state_ff     <= state_in;
         fmt_ff       <= fmt_in;
         phase_ff     <= phase_in;
         group_sum_ff <= group_sum_in;
         dot_sum_ff   <= dot_sum_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      csign_ff    <= csign_in;
      cmag_ff     <= cmag_in;
      act_ff      <= act_in;
      scale_ff    <= scale_in;
      gend_ff     <= gend_in;
      dend_ff     <= dend_in;
      sp_ff       <= sp_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      ep_ff       <= ep_in;
      sc_ff       <= sc_in;
      mc_ff       <= mc_in;
      ec_ff       <= ec_in;
      czero_ff    <= czero_in;
      pw_ff       <= pw_in;
      pe_ff       <= pe_in;
      nrm_ff      <= nrm_in;
      nrm_e_ff    <= nrm_e_in;
      rsgn_ff     <= rsgn_in;
      bexp_ff     <= bexp_in;
      res_ff      <= res_in;
   end

endmodule

>>> dv/group_quant_dot_product_tb.sv
module group_quant_dot_product_tb
   import gqdp_pkg::*;
();

   typedef struct {
      logic [7:0]  code_byte;
      logic [7:0]  high_byte;
      logic [5:0]  lane;
      logic [31:0] activation;
      logic [15:0] scale_half;
      logic        group_end;
      logic        dot_end;
   } elem_beat_type;

   // Running model of the two float sums; holds expected bf16 results in order.
   class dot_scoreboard;
      logic [1:0]  code_format;
      logic [31:0] group_acc;
      logic [31:0] dot_acc;
      logic [15:0] want_bf16[$];
      int          errors;

      function new();
         code_format = FMT_RESET;
         group_acc   = 32'd0;
         dot_acc     = 32'd0;
         errors      = 0;
      endfunction

      function int pending();
         return want_bf16.size();
      endfunction

      // float bits to double, NaN comes out quiet
      function real widen(logic [31:0] f);
         real v;
         if (f[30:23] == 8'hFF) begin
            if (f[22:0] == 23'd0) return $bitstoreal({f[31], 11'h7FF, 52'd0});
            return $bitstoreal({f[31], 11'h7FF, 1'b1, f[21:0], 29'd0});
         end
         if (f[30:0] == 31'd0) return $bitstoreal({f[31], 63'd0});
         if (f[30:23] == 8'd0) begin
            v = real'(f[22:0]) * (2.0 ** (-149));
            return f[31] ? -v : v;
         end
         return $bitstoreal({f[31], 11'(int'(f[30:23]) + 896), f[22:0], 29'd0});
      endfunction

      // double to float bits, round to nearest even, subnormals and overflow
      function logic [31:0] narrow(real x);
         logic [63:0] u, sig, q, rem, halfway;
         longint      tot;
         int          ex, shamt;
         u = $realtobits(x);
         if (u[62:52] == 11'h7FF) begin
            if (u[51:0] == 52'd0) return {u[63], 8'hFF, 23'd0};
            return {u[63], 8'hFF, 1'b1, u[50:29]};
         end
         if (u[62:0] == 63'd0) return {u[63], 31'd0};
         if (u[62:52] == 11'd0) begin
            sig = {12'd0, u[51:0]};
            ex  = -1022;
         end else begin
            sig = {11'd0, 1'b1, u[51:0]};
            ex  = int'(u[62:52]) - 1023;
         end
         shamt = (ex >= -126) ? 29 : 29 + (-126 - ex);
         if (shamt > 60) shamt = 60;
         q       = sig >> shamt;
         rem     = sig & ((64'd1 << shamt) - 64'd1);
         halfway = 64'd1 << (shamt - 1);
         if (rem > halfway || (rem == halfway && q[0])) q = q + 64'd1;
         if (ex >= -126) begin
            tot = (longint'(ex + 126) << 23) + longint'(q);
            if (tot >= (longint'(255) << 23)) return {u[63], 8'hFF, 23'd0};
            return {u[63], tot[30:0]};
         end
         return {u[63], q[30:0]};
      endfunction

      function logic [31:0] half_bits_to_single(logic [15:0] h);
         real v;
         if (h[14:10] == 5'd0) begin
            v = real'(h[9:0]) * (2.0 ** (-24));
            return narrow(h[15] ? -v : v);
         end
         if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
         return {h[15], 8'(int'(h[14:10]) + 112), h[9:0], 13'd0};
      endfunction

      // a*b+c with one rounding: exact double product, sum made round-to-odd
      function logic [31:0] madd_once(real a, real b, logic [31:0] c);
         real         p, cd, s, bb, err;
         logic [63:0] u;
         p  = a * b;
         cd = widen(c);
         s  = p + cd;
         if (s - s != 0.0 || s != s) return narrow(s);
         bb  = s - p;
         err = (p - (s - bb)) + (cd - bb);
         if (err != 0.0) begin
            u = $realtobits(s);
            if (u[0] == 1'b0) begin
               if ((err > 0.0) == (s > 0.0)) u = u + 64'd1;
               else u = u - 64'd1;
               s = $bitstoreal(u);
            end
         end
         return narrow(s);
      endfunction

      function logic [15:0] round_bf16(logic [31:0] f);
         logic [32:0] t;
         if (f[30:23] == 8'hFF && f[22:0] != 23'd0) return f[31:16] | 16'h0040;
         t = {1'b0, f} + 33'h7FFF + {32'd0, f[16]};
         return t[31:16];
      endfunction

      function int element_code(logic [7:0] cb, logic [7:0] hb, logic [5:0] lane);
         logic [3:0] nib;
         logic [5:0] full;
         if (code_format == FMT_Q8) return int'($signed(cb));
         nib = lane[0] ? cb[7:4] : cb[3:0];
         case (code_format)
            FMT_Q4: return int'($signed(nib));
            FMT_Q5: begin
               full = {1'b0, hb[lane[2:0]], nib};
               return full[4] ? int'(full) - 32 : int'(full);
            end
            default: begin
               full = {hb[(2 * lane + 1) % 8], hb[(2 * lane) % 8], nib};
               return full[5] ? int'(full) - 64 : int'(full);
            end
         endcase
      endfunction

      function void note_beat(elem_beat_type b);
         int code;
         code      = element_code(b.code_byte, b.high_byte, b.lane);
         group_acc = madd_once(real'(code), widen(b.activation), group_acc);
         if (b.group_end || b.dot_end) begin
            dot_acc   = madd_once(widen(group_acc), widen(half_bits_to_single(b.scale_half)),
                                  dot_acc);
            group_acc = 32'd0;
         end
         if (b.dot_end) begin
            want_bf16.push_back(round_bf16(dot_acc));
            dot_acc = 32'd0;
         end
      endfunction

      function void check_result(logic [15:0] got);
         logic [15:0] want;
         if (want_bf16.size() == 0) begin
            $error("result_bf16 expected none actual %h", got);
            errors++;
            return;
         end
         want = want_bf16.pop_front();
         if (got !== want) begin
            $error("result_bf16 expected %h actual %h", want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   burst_left;
   int   stall_mode;
   int   stall_count;
   int   sent;
   dot_scoreboard sb;

   gqdp_req_if req_bus();
   gqdp_rsp_if rsp_bus();
   gqdp_csr_if csr_bus();

   group_quant_dot_product u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Receiver: the stall mode is redrawn at random as stall_count runs; mode 0 never stalls.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) sb.check_result(rsp_bus.result_bf16);
      stall_count <= stall_count + 1;
      if (stall_count % 256 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         2: rsp_bus.ready <= (stall_count % 4 == 3);
         default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Hold the beat until accepted, then either keep valid up or drop it for a gap.
   task automatic put_beat(input elem_beat_type b);
      int gap;
      req_bus.valid      <= 1'b1;
      req_bus.code_byte  <= b.code_byte;
      req_bus.high_byte  <= b.high_byte;
      req_bus.lane       <= b.lane;
      req_bus.activation <= b.activation;
      req_bus.scale_half <= b.scale_half;
      req_bus.group_end  <= b.group_end;
      req_bus.dot_end    <= b.dot_end;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_beat(b);
      sent++;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         // now and then a long stretch with no idling at all
         burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(0, 15);
      end else begin
         burst_left--;
      end
   endtask

   task automatic put_fields(input logic [7:0] cb, input logic [7:0] hb, input logic [5:0] ln,
                             input logic [31:0] act, input logic [15:0] scl,
                             input logic ge, input logic de);
      elem_beat_type b;
      b.code_byte  = cb;
      b.high_byte  = hb;
      b.lane       = ln;
      b.activation = act;
      b.scale_half = scl;
      b.group_end  = ge;
      b.dot_end    = de;
      put_beat(b);
   endtask

   // Wait for every result to drain, give the datapath time to go idle, then write.
   task automatic write_format(input logic [1:0] fmt);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.code_format <= fmt;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.code_format = fmt;
   endtask

   // Mostly moderate magnitudes so sums stay meaningful; the odd one takes any bit pattern.
   function automatic logic [31:0] pick_activation();
      if ($urandom_range(0, 15) == 0) return $urandom;
      return {1'($urandom_range(0, 1)), 8'($urandom_range(117, 137)), 23'($urandom)};
   endfunction

   function automatic logic [15:0] pick_scale();
      if ($urandom_range(0, 15) == 0) return 16'($urandom);
      return {1'($urandom_range(0, 1)), 5'($urandom_range(8, 20)), 10'($urandom)};
   endfunction

   // One well-formed dot product: a few groups, lanes walking upward from a random start.
   task automatic put_dot();
      int         ngroups, glen;
      logic [5:0] ln;
      logic       last;
      ngroups = $urandom_range(1, 3);
      for (int g = 0; g < ngroups; g++) begin
         glen = $urandom_range(1, 6);
         ln   = 6'($urandom);
         for (int k = 0; k < glen; k++) begin
            last = (k == glen - 1);
            if (last && g == ngroups - 1) begin
               // dot end sometimes arrives without the group end flag
               put_fields(8'($urandom), 8'($urandom), ln, pick_activation(), pick_scale(),
                          ($urandom_range(0, 4) != 0), 1'b1);
            end else begin
               put_fields(8'($urandom), 8'($urandom), ln, pick_activation(), pick_scale(),
                          last, 1'b0);
            end
            ln++;
         end
      end
   endtask

   initial begin
      logic [1:0] fmt_seq[5];
      sb         = new();
      burst_left = 0;
      sent       = 0;
      fmt_seq    = '{FMT_Q4, FMT_Q5, FMT_Q6, FMT_Q8, FMT_Q4};
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.code_byte   <= 8'd0;
      req_bus.high_byte   <= 8'd0;
      req_bus.lane        <= 6'd0;
      req_bus.activation  <= 32'd0;
      req_bus.scale_half  <= 16'd0;
      req_bus.group_end   <= 1'b0;
      req_bus.dot_end     <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.code_format <= FMT_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part in the reset format: code extremes, float specials, NaN results.
      put_fields(8'h7F, 8'h00, 6'd0,  32'h3F80_0000, 16'h0000, 1'b0, 1'b0);
      put_fields(8'h80, 8'hFF, 6'd63, 32'hBF80_0000, 16'h3C00, 1'b1, 1'b0);
      put_fields(8'hFF, 8'h00, 6'd1,  32'h7F7F_FFFF, 16'h0000, 1'b0, 1'b0);
      put_fields(8'h01, 8'h00, 6'd2,  32'h0000_0001, 16'h7BFF, 1'b1, 1'b1);
      put_fields(8'h00, 8'h00, 6'd3,  32'h8000_0000, 16'h0001, 1'b0, 1'b1);
      put_fields(8'h05, 8'h00, 6'd4,  32'h7F80_0000, 16'h8000, 1'b0, 1'b1);
      put_fields(8'h02, 8'h00, 6'd5,  32'h7FC1_2345, 16'h3C00, 1'b1, 1'b1);
      put_fields(8'h03, 8'h00, 6'd6,  32'h3F00_0000, 16'h7C00, 1'b1, 1'b0);
      put_fields(8'h02, 8'h00, 6'd7,  32'h3F80_0000, 16'hFC00, 1'b1, 1'b1);
      put_fields(8'h10, 8'h00, 6'd8,  32'h7F00_0000, 16'h7BFF, 1'b1, 1'b1);
      put_fields(8'hFF, 8'hFF, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
      put_fields(8'h7F, 8'h55, 6'd9,  32'h4B00_0001, 16'h7E00, 1'b0, 1'b1);
      put_fields(8'h81, 8'hAA, 6'd10, 32'h0080_0000, 16'h03FF, 1'b1, 1'b1);

      // Random part: one phase per format plus one in a random format, mostly well-formed dots plus some noise.
      for (int ph = 0; ph < 5; ph++) begin
         write_format(ph == 4 ? 2'($urandom_range(0, 3)) : fmt_seq[ph]);
         while (sent < 13 + 270 * (ph + 1)) begin
            if ($urandom_range(0, 19) == 0)
               put_fields(8'($urandom), 8'($urandom), 6'($urandom), $urandom, 16'($urandom),
                          1'($urandom), 1'($urandom));
            else
               put_dot();
         end
      end
      // flush any group left open by noise so its result is checked too
      put_fields(8'($urandom), 8'($urandom), 6'($urandom), pick_activation(), pick_scale(),
                 1'b1, 1'b1);
      write_format(FMT_Q8);

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
